[design/tplp_pkg.sv]
package tplp_pkg;

  localparam int COUNT_WIDTH = 19;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0]  HDR_LEN    = 4'd12;
  localparam logic [3:0]  COLPFX_LEN = 4'd8;
  localparam logic [11:0] COLS_MAX   = 12'd256;
  localparam logic [11:0] NUM_MAX    = 12'd255;

  localparam logic [7:0] CH_BOM0  = 8'hEF;
  localparam logic [7:0] CH_BOM1  = 8'hBB;
  localparam logic [7:0] CH_BOM2  = 8'hBF;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic KIND_COLOR   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_HDR  = 2'd2,
    ST_NO_COLOR = 2'd3
  } status_e;

  // header modes sort below M_B_START; summary status relies on it
  typedef enum logic [3:0] {
    M_H_START     = 4'd0,
    M_H_BOM       = 4'd1,
    M_H_AFTERBOM  = 4'd2,
    M_H_MATCH     = 4'd3,
    M_H_FAIL      = 4'd4,
    M_B_START     = 4'd5,
    M_B_SKIP      = 4'd6,
    M_B_COLPFX    = 4'd7,
    M_B_COLSPACE  = 4'd8,
    M_B_COLDIGITS = 4'd9,
    M_B_COLDONE   = 4'd10,
    M_B_NUM       = 4'd11,
    M_B_GAP       = 4'd12,
    M_B_DONE      = 4'd13
  } mode_e;

  // classified input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_marker;
    logic       is_eol;
    logic       is_blank;
    logic       is_digit;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic                   kind;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic [COUNT_WIDTH-1:0] entry_index;
    logic [1:0]             status;
    logic [8:0]             column_count;
    logic [COUNT_WIDTH-1:0] colour_total;
    logic                   final_flag;
  } result_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] pos);
    logic [7:0] b;
    unique case (pos)
      4'd0:    b = 8'h47;
      4'd1:    b = 8'h49;
      4'd2:    b = 8'h4D;
      4'd3:    b = 8'h50;
      4'd4:    b = 8'h20;
      4'd5:    b = 8'h50;
      4'd6:    b = 8'h61;
      4'd7:    b = 8'h6C;
      4'd8:    b = 8'h65;
      4'd9:    b = 8'h74;
      4'd10:   b = 8'h74;
      4'd11:   b = 8'h65;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // "Columns:"
  function automatic logic [7:0] colpfx_byte(input logic [3:0] pos);
    logic [7:0] b;
    unique case (pos)
      4'd0:    b = 8'h43;
      4'd1:    b = 8'h6F;
      4'd2:    b = 8'h6C;
      4'd3:    b = 8'h75;
      4'd4:    b = 8'h6D;
      4'd5:    b = 8'h6E;
      4'd6:    b = 8'h73;
      4'd7:    b = 8'h3A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] bom_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0:    b = CH_BOM0;
      2'd1:    b = CH_BOM1;
      2'd2:    b = CH_BOM2;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [11:0] times_ten_add(input logic [11:0] v, input logic [3:0] d);
    logic [11:0] s;
    s = (v << 3) + (v << 1) + {8'd0, d};
    return s;
  endfunction

endpackage

[design/tplp_in_if.sv]
interface tplp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_marker;

  modport source (output valid, output data_byte, output end_marker, input ready);
  modport sink   (input valid, input data_byte, input end_marker, output ready);
endinterface

[design/tplp_out_if.sv]
interface tplp_out_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [7:0]                      red;
  logic [7:0]                      green;
  logic [7:0]                      blue;
  logic [tplp_pkg::COUNT_WIDTH-1:0] entry_index;
  logic [1:0]                      status;
  logic [8:0]                      column_count;
  logic [tplp_pkg::COUNT_WIDTH-1:0] colour_total;
  logic                            final_flag;

  modport source (output valid, output kind, output red, output green, output blue,
                  output entry_index, output status, output column_count,
                  output colour_total, output final_flag, input ready);
  modport sink   (input valid, input kind, input red, input green, input blue,
                  input entry_index, input status, input column_count,
                  input colour_total, input final_flag, output ready);
endinterface

[design/tplp_front.sv]
module tplp_front (
  tplp_in_if.sink          in_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output tplp_pkg::item_t  push_item_o
);
  import tplp_pkg::*;

  logic [7:0] c;

  assign c            = in_i.data_byte;
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  always_comb begin
    push_item_o            = '0;
    push_item_o.data_byte  = c;
    push_item_o.end_marker = in_i.end_marker;
    push_item_o.is_eol     = (c == CH_CR) || (c == CH_LF);
    // space, tab, VT, FF
    push_item_o.is_blank   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
    push_item_o.is_digit   = (c >= 8'h30) && (c <= 8'h39);
    push_item_o.digit      = c[3:0];
  end

endmodule

[design/tplp_queue.sv]
module tplp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  tplp_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output tplp_pkg::item_t pop_item_o
);
  import tplp_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

[design/tplp_back.sv]
module tplp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  tplp_pkg::item_t pop_item_i,
  tplp_out_if.source      out_o
);
  import tplp_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  mode_e                  mode_q, mode_d;
  logic [3:0]             match_q, match_d;
  logic [1:0]             bom_q, bom_d;
  logic [7:0]             num_q, num_d;
  logic                   seen_q, seen_d;
  logic [1:0]             slot_q, slot_d;
  logic [7:0]             red_q, red_d;
  logic [7:0]             green_q, green_d;
  logic [11:0]            colw_q, colw_d;
  logic                   neg_q, neg_d;
  logic [8:0]             colv_q, colv_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   any_q, any_d;
  logic                   hfail_q, hfail_d;

  // two-entry output buffer, ent0 is the head
  result_t                ent0_q, ent1_q;
  logic [1:0]             ocnt_q, ocnt_d;

  logic       act, emit_col, res_vld, take;
  result_t    res;
  logic [7:0] c;
  logic [11:0] colw_nx, num_nx;
  logic       opop, opush;

  assign c       = pop_item_i.data_byte;
  assign act     = pop_valid_i && (ocnt_q != 2'd2);
  assign colw_nx = times_ten_add(colw_q, pop_item_i.digit);
  assign num_nx  = times_ten_add({4'd0, num_q}, pop_item_i.digit);

  always_comb begin
    mode_d   = mode_q;
    match_d  = match_q;
    bom_d    = bom_q;
    num_d    = num_q;
    seen_d   = seen_q;
    slot_d   = slot_q;
    red_d    = red_q;
    green_d  = green_q;
    colw_d   = colw_q;
    neg_d    = neg_q;
    colv_d   = colv_q;
    count_d  = count_q;
    any_d    = any_q;
    hfail_d  = hfail_q;
    emit_col = 1'b0;
    res_vld  = 1'b0;
    take     = 1'b0;
    res      = '0;

    if (act) begin
      take = 1'b1;
      if (!pop_item_i.end_marker) begin
        any_d = 1'b1;
      end

      if (pop_item_i.end_marker || pop_item_i.is_eol) begin
        // close the open line
        unique case (mode_q)
          M_H_START, M_H_FAIL: begin
          end
          M_H_BOM, M_H_AFTERBOM: begin
            hfail_d = 1'b1;
            mode_d  = M_H_FAIL;
          end
          M_H_MATCH: begin
            if (match_q == HDR_LEN) begin
              mode_d = M_B_START;
            end else begin
              hfail_d = 1'b1;
              mode_d  = M_H_FAIL;
            end
          end
          M_B_COLSPACE, M_B_COLDIGITS, M_B_COLDONE: begin
            if (!neg_q && seen_q && (colw_q <= COLS_MAX)) begin
              colv_d = colw_q[8:0];
            end
            mode_d = M_B_START;
          end
          M_B_NUM: begin
            emit_col = (slot_q == 2'd2);
            mode_d   = M_B_START;
          end
          default: mode_d = M_B_START;
        endcase
        match_d = '0;
        bom_d   = '0;
        num_d   = '0;
        seen_d  = 1'b0;
        slot_d  = '0;
        colw_d  = '0;
        neg_d   = 1'b0;
      end else begin
        unique case (mode_q)
          M_H_START: begin
            if (!pop_item_i.is_blank) begin
              if (c == CH_BOM0) begin
                bom_d  = 2'd1;
                mode_d = M_H_BOM;
              end else if (c == hdr_byte(4'd0)) begin
                match_d = 4'd1;
                mode_d  = M_H_MATCH;
              end else begin
                hfail_d = 1'b1;
                mode_d  = M_H_FAIL;
              end
            end
          end
          M_H_BOM: begin
            if ((bom_q != 2'd3) && (c == bom_byte(bom_q))) begin
              bom_d = bom_q + 2'd1;
              if (bom_q == 2'd2) begin
                mode_d = M_H_AFTERBOM;
              end
            end else begin
              hfail_d = 1'b1;
              mode_d  = M_H_FAIL;
            end
          end
          M_H_AFTERBOM: begin
            if (!pop_item_i.is_blank) begin
              if (c == hdr_byte(4'd0)) begin
                match_d = 4'd1;
                mode_d  = M_H_MATCH;
              end else begin
                hfail_d = 1'b1;
                mode_d  = M_H_FAIL;
              end
            end
          end
          M_H_MATCH: begin
            if (match_q >= HDR_LEN) begin
              if (!pop_item_i.is_blank) begin
                hfail_d = 1'b1;
                mode_d  = M_H_FAIL;
              end
            end else if (c == hdr_byte(match_q)) begin
              match_d = match_q + 4'd1;
            end else begin
              hfail_d = 1'b1;
              mode_d  = M_H_FAIL;
            end
          end
          M_B_START: begin
            if (pop_item_i.is_blank) begin
            end else if (pop_item_i.is_digit) begin
              num_d  = {4'd0, pop_item_i.digit};
              slot_d = '0;
              mode_d = M_B_NUM;
            end else if (c == colpfx_byte(4'd0)) begin
              match_d = 4'd1;
              mode_d  = M_B_COLPFX;
            end else begin
              mode_d = M_B_SKIP;
            end
          end
          M_B_COLPFX: begin
            if ((match_q < COLPFX_LEN) && (c == colpfx_byte(match_q))) begin
              match_d = match_q + 4'd1;
              if (match_q == COLPFX_LEN - 4'd1) begin
                mode_d = M_B_COLSPACE;
              end
            end else begin
              mode_d = M_B_SKIP;
            end
          end
          M_B_COLSPACE: begin
            if (pop_item_i.is_blank) begin
            end else if (c == CH_MINUS) begin
              neg_d  = 1'b1;
              mode_d = M_B_COLDIGITS;
            end else if (pop_item_i.is_digit) begin
              colw_d = {8'd0, pop_item_i.digit};
              seen_d = 1'b1;
              mode_d = M_B_COLDIGITS;
            end else begin
              mode_d = M_B_COLDONE;
            end
          end
          M_B_COLDIGITS: begin
            if (pop_item_i.is_digit) begin
              colw_d = colw_nx;
              seen_d = 1'b1;
              if (colw_nx > COLS_MAX) begin
                mode_d = M_B_COLDONE;
              end
            end else begin
              mode_d = M_B_COLDONE;
            end
          end
          M_B_NUM: begin
            if (pop_item_i.is_digit) begin
              if (num_nx > NUM_MAX) begin
                mode_d = M_B_SKIP;
              end else begin
                num_d = num_nx[7:0];
              end
            end else if (slot_q == 2'd2) begin
              emit_col = 1'b1;
              mode_d   = M_B_DONE;
            end else if (pop_item_i.is_blank) begin
              if (slot_q == 2'd0) begin
                red_d = num_q;
              end else begin
                green_d = num_q;
              end
              slot_d = slot_q + 2'd1;
              mode_d = M_B_GAP;
            end else begin
              mode_d = M_B_SKIP;
            end
          end
          M_B_GAP: begin
            if (pop_item_i.is_blank) begin
            end else if (pop_item_i.is_digit) begin
              num_d  = {4'd0, pop_item_i.digit};
              mode_d = M_B_NUM;
            end else begin
              mode_d = M_B_SKIP;
            end
          end
          default: begin
          end
        endcase
      end

      if (emit_col) begin
        res_vld          = 1'b1;
        res.kind         = KIND_COLOR;
        res.red          = red_q;
        res.green        = green_q;
        res.blue         = num_q;
        res.entry_index  = count_q;
        res.final_flag   = !pop_item_i.end_marker;
        if (count_q != CNT_MAX) begin
          count_d = count_q + 1'b1;
        end
        // the summary follows from the same request, which stays at the queue head
        take = !pop_item_i.end_marker;
      end else if (pop_item_i.end_marker) begin
        res_vld          = 1'b1;
        res.kind         = KIND_SUMMARY;
        res.column_count = colv_d;
        res.colour_total = count_q;
        res.final_flag   = 1'b1;
        if (!any_q) begin
          res.status = ST_EMPTY;
        end else if (hfail_d || (mode_d < M_B_START)) begin
          res.status = ST_BAD_HDR;
        end else if (count_q == '0) begin
          res.status = ST_NO_COLOR;
        end else begin
          res.status = ST_OK;
        end
        mode_d  = M_H_START;
        red_d   = '0;
        green_d = '0;
        colv_d  = '0;
        count_d = '0;
        any_d   = 1'b0;
        hfail_d = 1'b0;
      end
    end
  end

  assign pop_ready_o = take;
  assign opush       = res_vld;
  assign opop        = out_o.valid && out_o.ready;

  always_comb begin
    ocnt_d = ocnt_q;
    if (opush && !opop) begin
      ocnt_d = ocnt_q + 2'd1;
    end else if (opop && !opush) begin
      ocnt_d = ocnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_H_START;
      match_q <= '0;
      bom_q   <= '0;
      num_q   <= '0;
      seen_q  <= 1'b0;
      slot_q  <= '0;
      red_q   <= '0;
      green_q <= '0;
      colw_q  <= '0;
      neg_q   <= 1'b0;
      colv_q  <= '0;
      count_q <= '0;
      any_q   <= 1'b0;
      hfail_q <= 1'b0;
      ocnt_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      match_q <= match_d;
      bom_q   <= bom_d;
      num_q   <= num_d;
      seen_q  <= seen_d;
      slot_q  <= slot_d;
      red_q   <= red_d;
      green_q <= green_d;
      colw_q  <= colw_d;
      neg_q   <= neg_d;
      colv_q  <= colv_d;
      count_q <= count_d;
      any_q   <= any_d;
      hfail_q <= hfail_d;
      ocnt_q  <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (opop) begin
      ent0_q <= (opush && (ocnt_q == 2'd1)) ? res : ent1_q;
      if (opush && (ocnt_q == 2'd2)) begin
        ent1_q <= res;
      end
    end else if (opush) begin
      if (ocnt_q == 2'd0) begin
        ent0_q <= res;
      end else begin
        ent1_q <= res;
      end
    end
  end

  assign out_o.valid        = (ocnt_q != 2'd0);
  assign out_o.kind         = ent0_q.kind;
  assign out_o.red          = ent0_q.red;
  assign out_o.green        = ent0_q.green;
  assign out_o.blue         = ent0_q.blue;
  assign out_o.entry_index  = ent0_q.entry_index;
  assign out_o.status       = ent0_q.status;
  assign out_o.column_count = ent0_q.column_count;
  assign out_o.colour_total = ent0_q.colour_total;
  assign out_o.final_flag   = ent0_q.final_flag;

  a_ocnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q != 2'd3) else $error("output buffer overflow");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ocnt_q == 2'd2) |=> $stable(mode_q) && $stable(count_q))
    else $error("parser moved while output buffer full");

  a_summary_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (opush && res.kind == KIND_SUMMARY) |=> (mode_q == M_H_START) && (count_q == '0))
    else $error("parser not restarted after summary");

  a_color_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (opush && res.kind == KIND_COLOR && count_q != CNT_MAX)
      |=> count_q == $past(count_q) + 1'b1)
    else $error("color count did not advance");

  a_split_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (opush && res.kind == KIND_COLOR && !res.final_flag) |-> !pop_ready_o)
    else $error("end marker consumed before its summary");

endmodule

[design/text_palette_line_parser.sv]
// Palette text parser.
// in_i  : one request per byte of the file (data_byte), or an end-of-file
//         request (end_marker = 1, data_byte ignored).
// out_o : color entries (kind 0) as each valid color line completes, and one
//         summary (kind 1) per end marker with status, column count and
//         color total; final_flag marks the last result of a request.
// Path: an accepted request is written into the input queue; the parser
// takes it from the queue head and loads its result into the output buffer.
// Throughput: one request per cycle while the output buffer is not full.
// An end marker that also finishes a color line gives two results, one per
// parser step, and stays at the queue head until its summary is buffered.
// Reset: the parser waits for the header line, counts are zero, queues are
// empty. After each summary it returns to the same state for the next file.
// Stall: a stalled receiver fills the two-entry output buffer; the parser
// then holds, the two-entry input queue fills and in_i.ready drops. Nothing
// is dropped on either side.
module text_palette_line_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  tplp_in_if.sink    in_i,
  tplp_out_if.source out_o
);
  import tplp_pkg::*;

  // front side: classify each byte and push it into the queue
  logic  push_valid, push_ready;
  item_t push_item;
  // back side: parser pulls from the queue head
  logic  pop_valid, pop_ready;
  item_t pop_item;

  tplp_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // decouples the byte intake from the parser so either side can stall
  tplp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // line state machine, number accumulation and result buffer
  tplp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_o       (out_o)
  );

endmodule
